// ----- rtl/hdf_pkg.sv -----
// Shared types, character constants and lookup functions for the hex dump formatter.
`default_nettype none

package hdf_pkg;

  // Byte that ends the stream like an end request does
  localparam logic [7:0] END_BYTE   = 8'h04;
  // Printable range for the text column
  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  // 'a' minus ten, so that digit 10 maps to 'a'
  localparam logic [7:0] CH_HEX_A = 8'h57;

  // One character of dump text on its way to the output register
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } hdf_char_t;

  // Lowercase hex digit of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + wide;
    end else begin
      return CH_HEX_A + wide;
    end
  endfunction

  // Text column character: the byte itself if printable, else a dot
  function automatic logic [7:0] text_char(input logic [7:0] b);
    if (b < PRINT_LOW || b > PRINT_HIGH) begin
      return CH_DOT;
    end else begin
      return b;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hdf_seq.sv -----
// Character sequencer: line buffer, address shifter and the per-character state machine.
`default_nettype none

module hdf_seq #(
  parameter int LINE_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input request
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_end,
  // character request toward the output register
  output logic                   ch_valid,
  input  wire logic              ch_ready,
  output hdf_pkg::hdf_char_t     ch
);
  import hdf_pkg::*;

  localparam int CW = $clog2(LINE_WIDTH);
  localparam int IW = CW + 1;
  localparam int MD = 1 << CW;
  localparam logic [CW-1:0] COL_LAST = CW'(LINE_WIDTH - 1);
  localparam logic [IW-1:0] IDX_FULL = IW'(LINE_WIDTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADDR  = 4'd1;
  localparam logic [3:0] S_COLON = 4'd2;
  localparam logic [3:0] S_GSP   = 4'd3;
  localparam logic [3:0] S_HI    = 4'd4;
  localparam logic [3:0] S_LO    = 4'd5;
  localparam logic [3:0] S_PAD   = 4'd6;
  localparam logic [3:0] S_TSP1  = 4'd7;
  localparam logic [3:0] S_TSP2  = 4'd8;
  localparam logic [3:0] S_TCHR  = 4'd9;
  localparam logic [3:0] S_TCR   = 4'd10;
  localparam logic [3:0] S_TLF   = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [2:0]    dig_r, dig_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          full_r, full_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    ps_r, ps_nxt;

  logic [7:0]    line_mem [MD];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic          go;
  logic          is_end;
  logic [IW-1:0] idx_inc;
  logic [3:0]    nib;

  assign in_ready = (state_r == S_IDLE);
  assign ch_valid = (state_r != S_IDLE);
  assign go       = ch_valid && ch_ready;
  assign is_end   = in_end || (in_byte == END_BYTE);
  assign mem_we   = in_valid && in_ready && !is_end;
  assign idx_inc  = idx_r + IW'(1);

  // Shared nibble select feeding the hex digit lookups
  always_comb begin
    unique case (state_r)
      S_ADDR:  nib = addr_r[31:28];
      S_HI:    nib = byte_r[7:4];
      default: nib = byte_r[3:0];
    endcase
  end

  // Character for the current state
  always_comb begin
    ch.last = 1'b0;
    unique case (state_r)
      S_ADDR, S_HI: ch.chr = hex_char(nib);
      S_LO: begin
        ch.chr  = hex_char(nib);
        ch.last = !full_r;
      end
      S_COLON: ch.chr = CH_COLON;
      S_TCHR:  ch.chr = text_char(rd_data_r);
      S_TCR:   ch.chr = CH_CR;
      S_TLF: begin
        ch.chr  = CH_LF;
        ch.last = 1'b1;
      end
      default: ch.chr = CH_SPACE;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    col_nxt   = col_r;
    addr_nxt  = addr_r;
    dig_nxt   = dig_r;
    byte_nxt  = byte_r;
    full_nxt  = full_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ps_nxt    = ps_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (is_end) begin
            pos_nxt = '0;
            col_nxt = '0;
            if (col_r != '0) begin
              cnt_nxt   = {1'b0, col_r};
              idx_nxt   = {1'b0, col_r};
              ps_nxt    = col_r[0] ? 2'd1 : 2'd0;
              state_nxt = S_PAD;
            end
          end else begin
            byte_nxt = in_byte;
            full_nxt = (col_r == COL_LAST);
            addr_nxt = pos_r;
            pos_nxt  = pos_r + 32'd1;
            col_nxt  = (col_r == COL_LAST) ? '0 : col_r + CW'(1);
            cnt_nxt  = IDX_FULL;
            idx_nxt  = '0;
            dig_nxt  = '0;
            if (col_r == '0) begin
              state_nxt = S_ADDR;
            end else if (!col_r[0]) begin
              state_nxt = S_GSP;
            end else begin
              state_nxt = S_HI;
            end
          end
        end
      end
      S_ADDR: begin
        if (go) begin
          addr_nxt = {addr_r[27:0], 4'd0};
          dig_nxt  = dig_r + 3'd1;
          if (dig_r == 3'd7) begin
            state_nxt = S_COLON;
          end
        end
      end
      S_COLON: if (go) state_nxt = S_GSP;
      S_GSP:   if (go) state_nxt = S_HI;
      S_HI:    if (go) state_nxt = S_LO;
      S_LO: begin
        if (go) begin
          state_nxt = full_r ? S_TSP1 : S_IDLE;
        end
      end
      S_PAD: begin
        // three spaces per missing even column, two per odd one
        if (go) begin
          if (ps_r == 2'd2) begin
            if (idx_inc == IDX_FULL) begin
              idx_nxt   = '0;
              state_nxt = S_TSP1;
            end else begin
              idx_nxt = idx_inc;
              ps_nxt  = idx_inc[0] ? 2'd1 : 2'd0;
            end
          end else begin
            ps_nxt = ps_r + 2'd1;
          end
        end
      end
      S_TSP1: if (go) state_nxt = S_TSP2;
      S_TSP2: if (go) state_nxt = S_TCHR;
      S_TCHR: begin
        if (go) begin
          if (idx_inc == cnt_r) begin
            state_nxt = S_TCR;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      S_TCR: if (go) state_nxt = S_TLF;
      S_TLF: if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      col_r   <= '0;
      dig_r   <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      ps_r    <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      dig_r   <= dig_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      ps_r    <= ps_nxt;
      full_r  <= full_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    byte_r <= byte_nxt;
  end

  // Line buffer; read address follows the next index so data lines up with idx_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col_r] <= in_byte;
    end
    rd_data_r <= line_mem[idx_nxt[CW-1:0]];
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ch_valid)
    else $error("input accepted while characters pending");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("column out of range");

  a_ch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ch_valid && !ch_ready |=> ch_valid && $stable(ch))
    else $error("character changed while stalled");

  a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAD |-> idx_r < IDX_FULL && cnt_r != '0)
    else $error("pad index out of range");

endmodule

`default_nettype wire

// ----- rtl/hex_dump_formatter_top.sv -----
// Top level of the hex dump formatter: sequencer plus the output register stage.
//
//  channel  dir  data                               flags
//  in_      in   in_tdata[7:0] = data_byte          in_tuser = end_of_stream
//  out_     out  out_tdata[7:0] = out_char          out_tlast = last
//
// Each input item, taken while idle, emits a group space before even columns and
// two hex digits for a plain byte, 9 more characters (address, colon) at a line start
// and LINE_WIDTH+4 more (two spaces, text, CR LF) at a line end; an end request pads a
// partial line and adds its text. The sequencer emits one character a cycle, unless
// stalled, through a single output register. in_tready is high only while it is idle.
// A stalled out_tready freezes the sequencer. Synchronous active-low reset zeroes the
// address; the line buffer is not cleared.
`default_nettype none

module hex_dump_formatter_top #(
  parameter int LINE_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] end_of_stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast
);
  import hdf_pkg::*;

  logic      ch_valid;
  logic      ch_ready;
  hdf_char_t ch;
  logic      out_valid_r;
  hdf_char_t out_r;

  hdf_seq #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_end   (in_tuser),
    .ch_valid (ch_valid),
    .ch_ready (ch_ready),
    .ch       (ch)
  );

  // Output register loads whenever empty or being drained
  assign ch_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ch_ready) begin
      out_valid_r <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_ready) begin
      out_r <= ch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.chr;
  assign out_tlast  = out_r.last;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the hex dump formatter: directed table plus random byte runs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hdf_pkg::*;

  localparam int LINE_W = 16;
  localparam int NUM_RANDOM = 95;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT_CHAR = 150;
  localparam logic [8*16-1:0] HEX_LUT = "0123456789abcdef";

  // One row of the directed stimulus table
  typedef struct {
    logic [7:0] data;
    logic       eos;
    bit         typed;   // expected text given in the row
    string      text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [7:0] out_tdata;
  logic out_tlast;

  // Mirror of the dump state
  logic [31:0] dump_addr;
  logic [7:0] line_buf [LINE_W];

  hdf_char_t line_chars [$];   // characters of the request being predicted
  hdf_char_t char_fifo [$];    // characters still owed by the block
  stim_row_t dir_rows [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int rx_chars = 0;
  int tx_calm = 0;
  int rx_calm = 0;

  always #6 clk = ~clk;

  hex_dump_formatter_top #(.LINE_WIDTH(LINE_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Wait draw for one request: usually a random gap, sometimes a run of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return HEX_LUT[(15 - nib) * 8 +: 8];
  endfunction

  function automatic void put_char(input logic [7:0] c);
    hdf_char_t ch;
    ch.chr = c;
    ch.last = 1'b0;
    line_chars.push_back(ch);
  endfunction

  // Two spaces, the text column of the bytes held, then CR LF
  function automatic void put_text(input int count);
    logic [7:0] b;
    put_char(CH_SPACE);
    put_char(CH_SPACE);
    for (int i = 0; i < count; i++) begin
      b = line_buf[i];
      put_char((b < PRINT_LOW || b > PRINT_HIGH) ? CH_DOT : b);
    end
    put_char(CH_CR);
    put_char(CH_LF);
  endfunction

  // Characters one request produces; updates the mirrored address and line
  function automatic void format_byte(input logic [7:0] b, input logic eos);
    int col;
    int n;
    line_chars.delete();
    col = int'(dump_addr % LINE_W);
    if (eos || b == END_BYTE) begin
      // flush a partial line: pad the missing columns, then the text
      if (col != 0) begin
        for (int i = col; i < LINE_W; i++) begin
          if (i % 2 == 0) put_char(CH_SPACE);
          put_char(CH_SPACE);
          put_char(CH_SPACE);
        end
        put_text(col);
      end
      dump_addr = '0;
    end else begin
      if (col == 0) begin
        for (int i = 7; i >= 0; i--) put_char(hex_digit(dump_addr[i*4 +: 4]));
        put_char(CH_COLON);
      end
      if (col % 2 == 0) put_char(CH_SPACE);
      put_char(hex_digit(b[7:4]));
      put_char(hex_digit(b[3:0]));
      line_buf[col] = b;
      dump_addr = dump_addr + 32'd1;
      if (col == LINE_W - 1) put_text(LINE_W);
    end
    n = line_chars.size();
    if (n > 0) line_chars[n-1].last = 1'b1;
  endfunction

  task automatic add_row(input logic [7:0] d, input logic e, input bit typed, input string txt);
    stim_row_t r;
    r.data = d;
    r.eos = e;
    r.typed = typed;
    r.text = txt;
    dir_rows.push_back(r);
  endtask

  // Offer one request, wait for it to be taken, queue what it should produce
  task automatic send_item(input logic [7:0] d, input logic e, input bit typed, input string txt);
    int gap;
    hdf_char_t ch;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= e;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    format_byte(d, e);
    if (typed) begin
      for (int i = 0; i < txt.len(); i++) begin
        ch.chr = txt[i];
        ch.last = (i == txt.len() - 1);
        char_fifo.push_back(ch);
      end
    end else begin
      foreach (line_chars[i]) char_fifo.push_back(line_chars[i]);
    end
  endtask

  // Sender: reset, directed table, then random runs of bytes closed by an end request
  initial begin
    int run_left;
    logic [7:0] d;
    logic e;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    dump_addr = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_row(8'hAA, 1'b1, 1'b1, "");              // end on an empty line
    add_row(8'h00, 1'b0, 1'b1, "00000000: 00");
    add_row(8'hFF, 1'b0, 1'b1, "ff");
    add_row(END_BYTE, 1'b0, 1'b0, "");           // end byte flushes an even column
    add_row(END_BYTE, 1'b0, 1'b1, "");           // end byte on an empty line
    add_row(8'h00, 1'b0, 1'b0, "");
    add_row(8'h1F, 1'b0, 1'b0, "");
    add_row(8'h20, 1'b0, 1'b0, "");
    add_row(8'h41, 1'b0, 1'b0, "");
    add_row(8'h7E, 1'b0, 1'b0, "");
    add_row(8'h7F, 1'b0, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    add_row(8'hFF, 1'b0, 1'b0, "");
    add_row(8'h5A, 1'b0, 1'b0, "");
    add_row(8'hA5, 1'b0, 1'b0, "");
    add_row(8'h0F, 1'b0, 1'b0, "");
    add_row(8'hF0, 1'b0, 1'b0, "");
    add_row(8'h7D, 1'b0, 1'b0, "");
    add_row(8'h21, 1'b0, 1'b0, "");
    add_row(8'h99, 1'b0, 1'b0, "");
    add_row(8'h30, 1'b0, 1'b0, "");              // full line with its text column
    add_row(8'h0F, 1'b0, 1'b1, "00000010: 0f");
    add_row(8'h3C, 1'b0, 1'b0, "");
    add_row(8'h7E, 1'b0, 1'b0, "");
    add_row(END_BYTE, 1'b1, 1'b0, "");           // end request flushes an odd column

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].text);
    end

    // Random part: runs of 1..40 requests, each closed by an end request or end byte, the last run possibly cut short
    run_left = $urandom_range(1, 40);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (run_left == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          d = 8'($urandom_range(0, 255));
          e = 1'b1;
        end else begin
          d = END_BYTE;
          e = 1'b0;
        end
        run_left = $urandom_range(1, 40);
      end else begin
        e = ($urandom_range(0, 49) == 0);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 5))
            0: d = 8'h00;
            1: d = 8'h1F;
            2: d = PRINT_LOW;
            3: d = PRINT_HIGH;
            4: d = 8'h7F;
            default: d = 8'hFF;
          endcase
        end else begin
          d = 8'($urandom_range(0, 255));
        end
        run_left--;
      end
      send_item(d, e, 1'b0, "");
    end
    in_tvalid <= 1'b0;

    // Drain, then give the block time to show any extra character
    while (char_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && char_fifo.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && rx_chars >= HOLD_AT_CHAR) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(rx_calm);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      rx_chars++;
    end
  end

  // Compare each character taken against the oldest one owed
  always @(posedge clk) begin
    hdf_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (char_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected char: got chr=%h last=%b", out_tdata, out_tlast);
        end
      end else begin
        want = char_fifo.pop_front();
        if (want.chr !== out_tdata || want.last !== out_tlast) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("char mismatch: exp chr=%h last=%b, got chr=%h last=%b",
                     want.chr, want.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  // Watchdog: too long with no request moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- sim.f -----
rtl/hdf_pkg.sv
rtl/hdf_seq.sv
rtl/hex_dump_formatter_top.sv
verif/tb_top.sv
